### rtl/ypcc_pkg.sv
`timescale 1ns / 1ps
// Package for the yaw/pitch camera controller.
// Holds widths, key codes, register indexes, the sequencer states, the arctangent
// table and the rounding and saturation helpers. It depends on nothing.
package ypcc_pkg;

    localparam int PIXEL_BITS   = 12;
    localparam int ANGLE_BITS   = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int RND_SHIFT    = 24 - ANGLE_BITS;
    localparam int PITCH_LIM    = (89 * (2 ** ANGLE_BITS)) / 360;
    localparam int DIV_BITS     = 51;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic [7:0] KEY_Q = 8'h71;
    localparam logic [7:0] KEY_W = 8'h77;
    localparam logic [7:0] KEY_S = 8'h73;
    localparam logic [7:0] KEY_A = 8'h61;
    localparam logic [7:0] KEY_D = 8'h64;

    localparam logic [2:0] CFG_SENS  = 3'd0;
    localparam logic [2:0] CFG_SPEED = 3'd1;
    localparam logic [2:0] CFG_UP_X  = 3'd2;
    localparam logic [2:0] CFG_UP_Y  = 3'd3;
    localparam logic [2:0] CFG_UP_Z  = 3'd4;

    typedef enum logic [4:0] {
        S_IDLE, S_PMUL_Y, S_PMUL_P, S_PANG, S_CINIT_P, S_CORD_P, S_CINIT_Y, S_CORD_Y,
        S_FMUL_X, S_FMUL_Z, S_FRONT, S_MV_MUL, S_MV_ADD, S_CR_A, S_CR_B, S_CR_C,
        S_SQ_MUL, S_SQ_ACC, S_ISQ, S_LEN, S_DV_MUL, S_DV_LOAD, S_DV_IT, S_DV_ADD,
        S_DONE
    } state_t;

    localparam logic [31:0] ATAN_TURNS [24] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

    // Divides by 2^s and rounds half away from zero.
    function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
                                                   input int s);
        logic [63:0] mag;
        logic [63:0] half;
        logic [63:0] q;
        mag  = v[63] ? 64'(-v) : 64'(v);
        half = (s == 0) ? 64'd0 : (64'd1 << (s - 1));
        q    = (mag + half) >> s;
        return v[63] ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic signed [15:0] clamp14(input logic signed [63:0] v);
        if (v > 64'sd16384)
            return 16'sd16384;
        else if (v < -64'sd16384)
            return -16'sd16384;
        else
            return v[15:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'h7FFFFFFF;
        else if (v < -64'sd2147483648)
            return 32'h80000000;
        else
            return v[31:0];
    endfunction

endpackage

### rtl/yaw_pitch_camera_controller.sv
`timescale 1ns / 1ps
// A pointer event takes two 16-step CORDIC runs on one shift-add unit, a w or s key
// a multiply and an add per axis, an a or d key a 32-step square root and three
// 51-step divisions on one shared divider.
// Throughput: one beat at a time; the next beat is taken once the result is in the
// output register. Reset clears the control and camera state and loads the register defaults.
// Depends on ypcc_pkg.
module yaw_pitch_camera_controller (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // mouse_x[11:0], mouse_y[23:12], key_code[31:24]
    input  logic         s_tuser,   // func
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [151:0] m_tdata,   // front_x, front_y, front_z, pos_x, pos_y, pos_z,
                                    // moved, quit, degenerate, zero fill
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [19:0]  cfg_data
);
    import ypcc_pkg::*;

    state_t state_reg, state_next;

    logic [15:0]        sens_reg;
    logic [19:0]        speed_reg;
    logic signed [15:0] up_reg [3];

    logic [ANGLE_BITS-1:0]        yaw_reg;
    logic signed [ANGLE_BITS-1:0] pitch_reg;
    logic [PIXEL_BITS-1:0]        last_px_reg, last_py_reg, px_reg, py_reg;
    logic                         first_reg;
    logic signed [15:0]           front_reg [3];
    logic signed [31:0]           pos_reg [3];

    logic [7:0]  key_reg;
    logic        moved_reg, quit_reg, degen_reg;
    logic [1:0]  k_reg;
    logic [5:0]  cnt_reg;

    logic signed [63:0] prod_reg, p1_reg;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p;

    logic signed [33:0] cx_reg, cy_reg, cz_reg;
    logic               flip_reg;
    logic signed [33:0] sp_reg, cp_reg;

    logic signed [31:0] c_reg [3];
    logic [63:0]        sum_reg, v_reg, r_reg;
    logic [31:0]        len_reg, rem_reg;
    logic [DIV_BITS-1:0] dvd_reg;
    logic               neg_reg;
    logic               m_valid_reg;
    logic [151:0]       m_data_reg;

    logic signed [33:0] cxv, cyv;
    logic signed [33:0] cx_sh, cy_sh, z_fold, z_start;
    logic signed [33:0] atan_v;
    logic [63:0]        bit_v, rsum;
    logic [33:0]        diff;
    logic signed [63:0] dval, pang, qval, dyaw;
    logic [63:0]        dmag;
    logic               ge;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign mul_p = mul_a * mul_b;
    assign cxv   = flip_reg ? -cx_reg : cx_reg;
    assign cyv   = flip_reg ? -cy_reg : cy_reg;
    assign cx_sh = cx_reg >>> cnt_reg[4:0];
    assign cy_sh = cy_reg >>> cnt_reg[4:0];
    assign atan_v = $signed({2'b00, ATAN_TURNS[cnt_reg[4:0]]});
    assign z_start = (state_reg == S_CINIT_P)
        ? 34'($signed({pitch_reg, {(32 - ANGLE_BITS){1'b0}}}))
        : 34'($signed({yaw_reg, {(32 - ANGLE_BITS){1'b0}}}));
    assign bit_v = 64'd1 << {~cnt_reg[4:0], 1'b0};
    assign rsum  = r_reg + bit_v;
    assign diff  = {1'b0, rem_reg, dvd_reg[DIV_BITS-1]} - {2'b00, len_reg};
    assign ge    = !diff[33];
    assign dval  = rnd_shr(prod_reg, 14);
    assign dyaw  = rnd_shr(prod_reg, RND_SHIFT);
    assign pang  = 64'(pitch_reg) + rnd_shr(prod_reg, RND_SHIFT);
    assign dmag  = (prod_reg[63] ? 64'(-prod_reg) : 64'(prod_reg)) + 64'(len_reg >> 1);
    assign qval  = neg_reg ? -$signed(64'(dvd_reg)) : $signed(64'(dvd_reg));

    always_comb
    begin
        if (z_start > 34'sd1073741824)
            z_fold = z_start - 34'sd2147483648;
        else if (z_start < -34'sd1073741824)
            z_fold = z_start + 34'sd2147483648;
        else
            z_fold = z_start;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (!s_tuser)
                        state_next = first_reg ? S_DONE : S_PMUL_Y;
                    else if (s_tdata[31:24] == KEY_W || s_tdata[31:24] == KEY_S)
                        state_next = S_MV_MUL;
                    else if (s_tdata[31:24] == KEY_A || s_tdata[31:24] == KEY_D)
                        state_next = S_CR_A;
                    else
                        state_next = S_DONE;
                end
            end
            S_PMUL_Y:  state_next = S_PMUL_P;
            S_PMUL_P:  state_next = S_PANG;
            S_PANG:    state_next = S_CINIT_P;
            S_CINIT_P: state_next = S_CORD_P;
            S_CORD_P:  state_next = (cnt_reg == 6'(CORDIC_STEPS - 1)) ? S_CINIT_Y : S_CORD_P;
            S_CINIT_Y: state_next = S_CORD_Y;
            S_CORD_Y:  state_next = (cnt_reg == 6'(CORDIC_STEPS - 1)) ? S_FMUL_X : S_CORD_Y;
            S_FMUL_X:  state_next = S_FMUL_Z;
            S_FMUL_Z:  state_next = S_FRONT;
            S_FRONT:   state_next = S_DONE;
            S_MV_MUL:  state_next = S_MV_ADD;
            S_MV_ADD:  state_next = (k_reg == 2'd2) ? S_DONE : S_MV_MUL;
            S_CR_A:    state_next = S_CR_B;
            S_CR_B:    state_next = S_CR_C;
            S_CR_C:    state_next = (k_reg == 2'd2) ? S_SQ_MUL : S_CR_A;
            S_SQ_MUL:  state_next = S_SQ_ACC;
            S_SQ_ACC:  state_next = (k_reg == 2'd2) ? S_ISQ : S_SQ_MUL;
            S_ISQ:     state_next = (cnt_reg == 6'd31) ? S_LEN : S_ISQ;
            S_LEN:     state_next = (r_reg == 64'd0) ? S_DONE : S_DV_MUL;
            S_DV_MUL:  state_next = S_DV_LOAD;
            S_DV_LOAD: state_next = S_DV_IT;
            S_DV_IT:   state_next = (cnt_reg == 6'(DIV_BITS - 1)) ? S_DV_ADD : S_DV_IT;
            S_DV_ADD:  state_next = (k_reg == 2'd2) ? S_DONE : S_DV_MUL;
            S_DONE:    state_next = (!m_valid_reg || m_tready) ? S_IDLE : S_DONE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        mul_a = 32'sd0;
        mul_b = 32'sd0;
        case (state_reg)
            S_PMUL_Y:
            begin
                mul_a = 32'($signed({1'b0, px_reg}) - $signed({1'b0, last_px_reg}));
                mul_b = $signed({16'd0, sens_reg});
            end
            S_PMUL_P:
            begin
                mul_a = 32'($signed({1'b0, last_py_reg}) - $signed({1'b0, py_reg}));
                mul_b = $signed({16'd0, sens_reg});
            end
            S_FMUL_X:
            begin
                mul_a = cp_reg[31:0];
                mul_b = cxv[31:0];
            end
            S_FMUL_Z:
            begin
                mul_a = cp_reg[31:0];
                mul_b = cyv[31:0];
            end
            S_MV_MUL:
            begin
                mul_a = 32'(front_reg[k_reg]);
                mul_b = $signed({12'd0, speed_reg});
            end
            S_CR_A:
            begin
                case (k_reg)
                    2'd0:    begin mul_a = 32'(up_reg[1]); mul_b = 32'(front_reg[2]); end
                    2'd1:    begin mul_a = 32'(up_reg[2]); mul_b = 32'(front_reg[0]); end
                    default: begin mul_a = 32'(up_reg[0]); mul_b = 32'(front_reg[1]); end
                endcase
            end
            S_CR_B:
            begin
                case (k_reg)
                    2'd0:    begin mul_a = 32'(up_reg[2]); mul_b = 32'(front_reg[1]); end
                    2'd1:    begin mul_a = 32'(up_reg[0]); mul_b = 32'(front_reg[2]); end
                    default: begin mul_a = 32'(up_reg[1]); mul_b = 32'(front_reg[0]); end
                endcase
            end
            S_SQ_MUL:
            begin
                mul_a = c_reg[k_reg];
                mul_b = c_reg[k_reg];
            end
            S_DV_MUL:
            begin
                mul_a = c_reg[k_reg];
                mul_b = $signed({12'd0, speed_reg});
            end
            default:
            begin
                mul_a = 32'sd0;
                mul_b = 32'sd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            sens_reg    <= 16'd2276;
            speed_reg   <= 20'd6554;
            up_reg[0]   <= 16'sd0;
            up_reg[1]   <= 16'sd16384;
            up_reg[2]   <= 16'sd0;
            yaw_reg     <= '0;
            pitch_reg   <= '0;
            last_px_reg <= '0;
            last_py_reg <= '0;
            first_reg   <= 1'b1;
            front_reg[0] <= 16'sd16384;
            front_reg[1] <= 16'sd0;
            front_reg[2] <= 16'sd0;
            pos_reg[0]  <= 32'sd0;
            pos_reg[1]  <= 32'sd0;
            pos_reg[2]  <= 32'sd0;
            m_valid_reg <= 1'b0;
            moved_reg   <= 1'b0;
            quit_reg    <= 1'b0;
            degen_reg   <= 1'b0;
            k_reg       <= 2'd0;
            cnt_reg     <= 6'd0;
        end
        else
        begin
            state_reg <= state_next;
            prod_reg  <= mul_p;

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SENS:  sens_reg  <= cfg_data[15:0];
                    CFG_SPEED: speed_reg <= cfg_data;
                    CFG_UP_X:  up_reg[0] <= cfg_data[15:0];
                    CFG_UP_Y:  up_reg[1] <= cfg_data[15:0];
                    CFG_UP_Z:  up_reg[2] <= cfg_data[15:0];
                    default:   ;
                endcase
            end

            if (state_reg == S_DONE && (!m_valid_reg || m_tready))
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        moved_reg <= 1'b0;
                        quit_reg  <= s_tuser && (s_tdata[31:24] == KEY_Q);
                        degen_reg <= 1'b0;
                        k_reg     <= 2'd0;
                        sum_reg   <= 64'd0;
                        key_reg   <= s_tdata[31:24];
                        px_reg    <= s_tdata[PIXEL_BITS-1:0];
                        py_reg    <= s_tdata[12 +: PIXEL_BITS];
                        if (!s_tuser && first_reg)
                        begin
                            first_reg   <= 1'b0;
                            last_px_reg <= s_tdata[PIXEL_BITS-1:0];
                            last_py_reg <= s_tdata[12 +: PIXEL_BITS];
                        end
                    end
                end
                S_PMUL_P:
                    yaw_reg <= yaw_reg + dyaw[ANGLE_BITS-1:0];
                S_PANG:
                begin
                    if (pang > 64'(PITCH_LIM))
                        pitch_reg <= ANGLE_BITS'(PITCH_LIM);
                    else if (pang < -64'(PITCH_LIM))
                        pitch_reg <= ANGLE_BITS'(-PITCH_LIM);
                    else
                        pitch_reg <= pang[ANGLE_BITS-1:0];
                    last_px_reg <= px_reg;
                    last_py_reg <= py_reg;
                end
                S_CINIT_P, S_CINIT_Y:
                begin
                    if (state_reg == S_CINIT_Y)
                    begin
                        sp_reg <= cyv;
                        cp_reg <= cxv;
                    end
                    cx_reg   <= CORDIC_GAIN;
                    cy_reg   <= 34'sd0;
                    cz_reg   <= z_fold;
                    flip_reg <= (z_fold != z_start);
                    cnt_reg  <= 6'd0;
                end
                S_CORD_P, S_CORD_Y:
                begin
                    if (!cz_reg[33])
                    begin
                        cx_reg <= cx_reg - cy_sh;
                        cy_reg <= cy_reg + cx_sh;
                        cz_reg <= cz_reg - atan_v;
                    end
                    else
                    begin
                        cx_reg <= cx_reg + cy_sh;
                        cy_reg <= cy_reg - cx_sh;
                        cz_reg <= cz_reg + atan_v;
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                end
                S_FMUL_Z:
                    front_reg[0] <= clamp14(rnd_shr(prod_reg, 46));
                S_FRONT:
                begin
                    front_reg[2] <= clamp14(rnd_shr(prod_reg, 46));
                    front_reg[1] <= clamp14(rnd_shr(64'(sp_reg), 16));
                end
                S_MV_ADD:
                begin
                    pos_reg[k_reg] <= sat32(64'(pos_reg[k_reg])
                                            + ((key_reg == KEY_S) ? -dval : dval));
                    k_reg <= (k_reg == 2'd2) ? 2'd0 : k_reg + 2'd1;
                    if (k_reg == 2'd2)
                        moved_reg <= 1'b1;
                end
                S_CR_B:
                    p1_reg <= prod_reg;
                S_CR_C:
                begin
                    c_reg[k_reg] <= (key_reg == KEY_D) ? 32'(prod_reg - p1_reg)
                                                       : 32'(p1_reg - prod_reg);
                    k_reg <= (k_reg == 2'd2) ? 2'd0 : k_reg + 2'd1;
                end
                S_SQ_ACC:
                begin
                    sum_reg <= sum_reg + prod_reg;
                    k_reg   <= (k_reg == 2'd2) ? 2'd0 : k_reg + 2'd1;
                    if (k_reg == 2'd2)
                    begin
                        v_reg   <= sum_reg + prod_reg;
                        r_reg   <= 64'd0;
                        cnt_reg <= 6'd0;
                    end
                end
                S_ISQ:
                begin
                    if (v_reg >= rsum)
                    begin
                        v_reg <= v_reg - rsum;
                        r_reg <= (r_reg >> 1) + bit_v;
                    end
                    else
                        r_reg <= r_reg >> 1;
                    cnt_reg <= cnt_reg + 6'd1;
                end
                S_LEN:
                begin
                    len_reg <= r_reg[31:0];
                    if (r_reg == 64'd0)
                        degen_reg <= 1'b1;
                end
                S_DV_LOAD:
                begin
                    dvd_reg <= dmag[DIV_BITS-1:0];
                    neg_reg <= prod_reg[63];
                    rem_reg <= 32'd0;
                    cnt_reg <= 6'd0;
                end
                S_DV_IT:
                begin
                    rem_reg <= ge ? diff[31:0] : {rem_reg[30:0], dvd_reg[DIV_BITS-1]};
                    dvd_reg <= {dvd_reg[DIV_BITS-2:0], ge};
                    cnt_reg <= cnt_reg + 6'd1;
                end
                S_DV_ADD:
                begin
                    pos_reg[k_reg] <= sat32(64'(pos_reg[k_reg]) + qval);
                    k_reg <= (k_reg == 2'd2) ? 2'd0 : k_reg + 2'd1;
                    if (k_reg == 2'd2)
                        moved_reg <= 1'b1;
                end
                S_DONE:
                begin
                    if (!m_valid_reg || m_tready)
                    begin
                        m_data_reg  <= {5'd0, degen_reg, quit_reg, moved_reg,
                                        pos_reg[2], pos_reg[1], pos_reg[0],
                                        front_reg[2], front_reg[1], front_reg[0]};
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

### bench/tb_yaw_pitch_camera_controller.sv
`timescale 1ns / 1ps
// Testbench for yaw_pitch_camera_controller: a directed table and zero-up strafes, then random
// pointer and key beats under several register settings, checked field by field against a
// built-in predictor. Depends on ypcc_pkg and the controller RTL.
module tb_yaw_pitch_camera_controller;
    import ypcc_pkg::*;

    typedef struct {
        bit         func;
        bit [11:0]  px;
        bit [11:0]  py;
        bit [7:0]   key;
        bit         typed;
        bit [2:0]   flags;
    } dir_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [31:0]  s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [151:0] m_tdata;
    logic         cfg_we;
    logic [2:0]   cfg_index;
    logic [19:0]  cfg_data;

    yaw_pitch_camera_controller DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    localparam int FLD_LSB [9] = '{0, 16, 32, 48, 80, 112, 144, 145, 146};
    localparam int FLD_W   [9] = '{16, 16, 16, 32, 32, 32, 1, 1, 1};
    localparam string FLD_NAME [9] = '{"front_x", "front_y", "front_z", "pos_x", "pos_y",
                                       "pos_z", "moved", "quit", "degenerate"};

    logic [151:0] pending_views[$];
    int           mismatches;
    int           beats_out;
    int           n_ptr;
    int           n_key;
    int           n_degen;
    bit           calm;

    bit [15:0]    cam_sens;
    bit [19:0]    cam_speed;
    longint       cam_up [3];
    bit [15:0]    cam_yaw;
    longint       cam_pitch;
    bit [11:0]    cam_lx;
    bit [11:0]    cam_ly;
    bit           cam_first;
    longint       cam_front [3];
    longint       cam_pos [3];

    always #5 clk = ~clk;

    function automatic longint div_round(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint sat_pos(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint clip14(longint v);
        if (v > 16384)
            return 16384;
        if (v < -16384)
            return -16384;
        return v;
    endfunction

    task automatic rotate(input bit [31:0] ang, output longint s, output longint c);
        longint z;
        longint x;
        longint y;
        longint nx;
        bit     flip;
        z = longint'($signed(ang));
        x = 652032874;
        y = 0;
        flip = 0;
        if (z > 64'sd1073741824) begin
            z = z - 64'sd2147483648;
            flip = 1;
        end
        else if (z < -64'sd1073741824) begin
            z = z + 64'sd2147483648;
            flip = 1;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - longint'(ATAN_TURNS[i]);
            end
            else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + longint'(ATAN_TURNS[i]);
            end
            x = nx;
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endtask

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    task automatic cam_reset();
        cam_sens = 16'd2276;
        cam_speed = 20'd6554;
        cam_up = '{0, 16384, 0};
        cam_yaw = 0;
        cam_pitch = 0;
        cam_lx = 0;
        cam_ly = 0;
        cam_first = 1;
        cam_front = '{16384, 0, 0};
        cam_pos = '{0, 0, 0};
    endtask

    task automatic cam_event(input bit func, input bit [11:0] px, input bit [11:0] py,
                             input bit [7:0] key, output logic [151:0] view);
        bit     mv;
        bit     qt;
        bit     dg;
        longint dyaw;
        longint dpit;
        longint sp, cp, sy, cy;
        longint step;
        longint cr [3];
        longint unsigned sum;
        longint unsigned len;
        longint spd;
        mv = 0;
        qt = 0;
        dg = 0;
        spd = longint'(cam_speed);
        if (!func) begin
            if (cam_first)
                cam_first = 0;
            else begin
                dyaw = div_round((longint'(px) - longint'(cam_lx)) * longint'(cam_sens),
                                 1 << RND_SHIFT);
                dpit = div_round((longint'(cam_ly) - longint'(py)) * longint'(cam_sens),
                                 1 << RND_SHIFT);
                cam_yaw = cam_yaw + dyaw[15:0];
                cam_pitch = cam_pitch + dpit;
                if (cam_pitch > PITCH_LIM)
                    cam_pitch = PITCH_LIM;
                if (cam_pitch < -PITCH_LIM)
                    cam_pitch = -PITCH_LIM;
                rotate({cam_pitch[15:0], 16'h0}, sp, cp);
                rotate({cam_yaw, 16'h0}, sy, cy);
                cam_front[0] = clip14(div_round(cp * cy, 64'sd1 << 46));
                cam_front[1] = clip14(div_round(sp, 64'sd1 << 16));
                cam_front[2] = clip14(div_round(cp * sy, 64'sd1 << 46));
            end
            cam_lx = px;
            cam_ly = py;
        end
        else if (key == KEY_Q)
            qt = 1;
        else if (key == KEY_W || key == KEY_S) begin
            for (int k = 0; k < 3; k++) begin
                step = div_round(cam_front[k] * spd, 16384);
                cam_pos[k] = sat_pos(cam_pos[k] + ((key == KEY_W) ? step : -step));
            end
            mv = 1;
        end
        else if (key == KEY_A || key == KEY_D) begin
            cr[0] = cam_up[1] * cam_front[2] - cam_up[2] * cam_front[1];
            cr[1] = cam_up[2] * cam_front[0] - cam_up[0] * cam_front[2];
            cr[2] = cam_up[0] * cam_front[1] - cam_up[1] * cam_front[0];
            sum = 0;
            for (int k = 0; k < 3; k++) begin
                if (key == KEY_D)
                    cr[k] = -cr[k];
                sum = sum + longint'(cr[k] * cr[k]);
            end
            len = root_floor(sum);
            if (len == 0)
                dg = 1;
            else begin
                for (int k = 0; k < 3; k++)
                    cam_pos[k] = sat_pos(cam_pos[k] + div_round(cr[k] * spd, longint'(len)));
                mv = 1;
            end
        end
        view = '0;
        view[15:0] = cam_front[0][15:0];
        view[31:16] = cam_front[1][15:0];
        view[47:32] = cam_front[2][15:0];
        view[79:48] = cam_pos[0][31:0];
        view[111:80] = cam_pos[1][31:0];
        view[143:112] = cam_pos[2][31:0];
        view[146:144] = {dg, qt, mv};
    endtask

    task automatic send_event(input bit func, input bit [11:0] px, input bit [11:0] py,
                              input bit [7:0] key, input bit typed, input bit [2:0] flags);
        logic [151:0] view;
        while (!calm && $urandom_range(99) < 30) begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser <= func;
        s_tdata <= {key, py, px};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        cam_event(func, px, py, key, view);
        if (typed)
            view[146:144] = flags;
        pending_views.push_back(view);
        if (func)
            n_key++;
        else
            n_ptr++;
        if (view[146])
            n_degen++;
    endtask

    task automatic drain(input int tail);
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_views.size() != 0)
            @(posedge clk);
        repeat (tail)
            @(posedge clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [19:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_SENS:  cam_sens = val[15:0];
            CFG_SPEED: cam_speed = val;
            CFG_UP_X:  cam_up[0] = longint'($signed(val[15:0]));
            CFG_UP_Y:  cam_up[1] = longint'($signed(val[15:0]));
            CFG_UP_Z:  cam_up[2] = longint'($signed(val[15:0]));
            default: ;
        endcase
    endtask

    task automatic set_all(input logic [19:0] sens, input logic [19:0] speed,
                           input logic [19:0] ux, input logic [19:0] uy,
                           input logic [19:0] uz);
        drain(250);
        cfg_write(CFG_SENS, sens);
        cfg_write(CFG_SPEED, speed);
        cfg_write(CFG_UP_X, ux);
        cfg_write(CFG_UP_Y, uy);
        cfg_write(CFG_UP_Z, uz);
    endtask

    task automatic random_events(input int count);
        bit [11:0] px;
        bit [11:0] py;
        bit [7:0]  key;
        bit        func;
        for (int i = 0; i < count; i++) begin
            func = 1'($urandom_range(1));
            px = 12'($urandom);
            py = 12'($urandom);
            if ($urandom_range(99) < 60) begin
                px = cam_lx + 12'($urandom_range(64) - 32);
                py = cam_ly + 12'($urandom_range(64) - 32);
            end
            case ($urandom_range(9))
                0, 1:    key = KEY_W;
                2:       key = KEY_S;
                3, 4:    key = KEY_A;
                5:       key = KEY_D;
                6:       key = KEY_Q;
                default: key = 8'($urandom);
            endcase
            send_event(func, px, py, key, 1'b0, 3'b000);
        end
    endtask

    always @(negedge clk)
        m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 30);

    always @(posedge clk) begin
        logic [151:0] want;
        longint       exp_v;
        longint       got_v;
        bit           bad;
        if (m_tvalid && m_tready) begin
            beats_out++;
            if (pending_views.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %h", m_tdata);
            end
            else begin
                want = pending_views.pop_front();
                bad = 0;
                for (int f = 0; f < 9; f++) begin
                    exp_v = longint'((want >> FLD_LSB[f]) & ((152'd1 << FLD_W[f]) - 1));
                    got_v = longint'((m_tdata >> FLD_LSB[f]) & ((152'd1 << FLD_W[f]) - 1));
                    if (exp_v != got_v) begin
                        bad = 1;
                        if (mismatches < 10)
                            $display("beat %0d %s: expected %h, got %h",
                                     beats_out, FLD_NAME[f], exp_v, got_v);
                    end
                end
                if (bad)
                    mismatches++;
            end
        end
    end

    initial begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        dir_row_t dir_tab[$];
        clk = 0;
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = 0;
        m_tready = 0;
        cfg_we = 0;
        cfg_index = CFG_SENS;
        cfg_data = '0;
        mismatches = 0;
        beats_out = 0;
        n_ptr = 0;
        n_key = 0;
        n_degen = 0;
        calm = 0;
        cam_reset();

        dir_tab.push_back('{1, 0, 0, KEY_W, 1, 3'b001});
        dir_tab.push_back('{1, 0, 0, KEY_S, 1, 3'b001});
        dir_tab.push_back('{1, 0, 0, KEY_A, 1, 3'b001});
        dir_tab.push_back('{1, 0, 0, KEY_D, 1, 3'b001});
        dir_tab.push_back('{1, 12'hFFF, 12'hFFF, KEY_Q, 1, 3'b010});
        dir_tab.push_back('{1, 0, 0, 8'h00, 1, 3'b000});
        dir_tab.push_back('{1, 0, 0, 8'hFF, 1, 3'b000});
        dir_tab.push_back('{0, 0, 0, 8'hFF, 1, 3'b000});
        dir_tab.push_back('{0, 12'hFFF, 12'hFFF, KEY_W, 1, 3'b000});
        dir_tab.push_back('{0, 0, 0, 8'h00, 1, 3'b000});
        dir_tab.push_back('{0, 12'hFFF, 0, 8'h00, 1, 3'b000});
        dir_tab.push_back('{0, 0, 12'hFFF, 8'h00, 1, 3'b000});
        dir_tab.push_back('{1, 0, 0, KEY_W, 0, 3'b000});
        dir_tab.push_back('{1, 0, 0, KEY_A, 0, 3'b000});
        dir_tab.push_back('{0, 12'h800, 12'h800, 8'h00, 0, 3'b000});
        dir_tab.push_back('{1, 0, 0, KEY_D, 0, 3'b000});
        dir_tab.push_back('{1, 0, 0, KEY_S, 0, 3'b000});

        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[i])
            send_event(dir_tab[i].func, dir_tab[i].px, dir_tab[i].py, dir_tab[i].key,
                       dir_tab[i].typed, dir_tab[i].flags);

        set_all(20'd2276, 20'd0, 20'd0, 20'd0, 20'd0);
        send_event(1, 0, 0, KEY_A, 1, 3'b100);
        send_event(1, 0, 0, KEY_D, 1, 3'b100);
        send_event(1, 0, 0, KEY_W, 1, 3'b001);

        set_all(20'hFFFFF, 20'hFFFFF, 20'd16384, 20'd16384, 20'd16384);
        random_events(100);
        set_all(20'h00000, 20'd1, 20'hFC000, 20'h0C000, 20'hFC000);
        random_events(60);
        calm = 1;
        set_all(20'd2276, 20'd6554, 20'd0, 20'd16384, 20'd0);
        random_events(120);
        calm = 0;
        set_all(20'd40000, 20'd300000, 20'h08000, 20'h07FFF, 20'h00000);
        random_events(80);
        for (int p = 0; p < 4; p++) begin
            set_all(20'($urandom), 20'($urandom), 20'($urandom), 20'($urandom),
                    20'($urandom));
            random_events(70);
        end
        drain(250);

        $display("Sent %0d pointer and %0d key beats over eight register settings.",
                 n_ptr, n_key);
        $display("Results checked: %0d, degenerate strafes: %0d, mismatches: %0d.",
                 beats_out, n_degen, mismatches);
        if (mismatches == 0 && pending_views.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
